// File: hdl/pht_pkg.sv
// shared constants and control type for the polygon hit-test block
`default_nettype none
package pht_pkg;

  // payload field widths
  localparam int FIELD_W = 16;
  localparam int IDX_W   = 7;
  localparam int HIT_W   = 8;

  // saturation limit of the hit counter
  localparam logic [HIT_W-1:0] HIT_SAT = 8'd255;

  // parameter defaults
  localparam int SHAPE_LIMIT_DEF = 128;
  localparam int COORD_WIDTH_DEF = 16;

  // per-beat control carried down the pipeline
  typedef struct packed {
    logic edge_v;      // the edge from the previous vertex is live
    logic close_v;     // the closing edge is live and the shape closes
    logic last_scene;  // beat ends the scene and emits a result
  } pht_ctl_t;

endpackage
`default_nettype wire

// File: hdl/pht_ifs.sv
// valid/ready channel interfaces for the input and result beats
`default_nettype none
interface pht_in_if import pht_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] point_x;
  logic signed [FIELD_W-1:0] point_y;
  logic signed [FIELD_W-1:0] vertex_x;
  logic signed [FIELD_W-1:0] vertex_y;
  logic                      has_vertex;
  logic                      last_in_shape;
  logic                      last_in_scene;

  modport source (
    output valid, point_x, point_y, vertex_x, vertex_y,
           has_vertex, last_in_shape, last_in_scene,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, vertex_x, vertex_y,
           has_vertex, last_in_shape, last_in_scene,
    output ready
  );
endinterface

interface pht_out_if import pht_pkg::*; ;
  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] top_shape_index;
  logic [HIT_W-1:0] hit_count;
  logic             shape_overflow;

  modport source (
    output valid, found, top_shape_index, hit_count, shape_overflow,
    input  ready
  );
  modport sink (
    input  valid, found, top_shape_index, hit_count, shape_overflow,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/pht_front.sv
// input stage: vertex tracking and edge operand register
`default_nettype none
module pht_front import pht_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   acc,
  input  wire logic                   s1_go,
  input  wire logic [FIELD_W-1:0]     point_x,
  input  wire logic [FIELD_W-1:0]     point_y,
  input  wire logic [FIELD_W-1:0]     vertex_x,
  input  wire logic [FIELD_W-1:0]     vertex_y,
  input  wire logic                   has_vertex,
  input  wire logic                   last_in_shape,
  input  wire logic                   last_in_scene,
  output logic                        s1_v,
  output pht_ctl_t                    s1_ctl,
  output logic signed [CW-1:0]        tx_r,
  output logic signed [CW-1:0]        ty_r,
  output logic signed [CW-1:0]        e_xi_r,
  output logic signed [CW-1:0]        e_yi_r,
  output logic signed [CW-1:0]        e_xj_r,
  output logic signed [CW-1:0]        e_yj_r,
  output logic signed [CW-1:0]        c_xi_r,
  output logic signed [CW-1:0]        c_yi_r
);

  logic [CW+FIELD_W-1:0] px_ext, py_ext, vx_ext, vy_ext;
  logic signed [CW-1:0]  tx, ty, vx, vy, fx_use, fy_use;
  logic signed [CW-1:0]  first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic                  at_start_r, at_start_nxt;
  logic                  s1_v_r, s1_v_nxt;
  pht_ctl_t              ctl_r, ctl_nxt;
  logic                  shape_done;

  // coordinates: low CW bits of the field, read as two's complement
  assign px_ext = {{CW{1'b0}}, point_x};
  assign py_ext = {{CW{1'b0}}, point_y};
  assign vx_ext = {{CW{1'b0}}, vertex_x};
  assign vy_ext = {{CW{1'b0}}, vertex_y};
  assign tx = $signed(px_ext[CW-1:0]);
  assign ty = $signed(py_ext[CW-1:0]);
  assign vx = $signed(vx_ext[CW-1:0]);
  assign vy = $signed(vy_ext[CW-1:0]);

  // first vertex of the shape, this one when the shape opens here
  assign fx_use = at_start_r ? vx : first_x_r;
  assign fy_use = at_start_r ? vy : first_y_r;

  // control decode for the accepted beat
  assign shape_done = has_vertex & last_in_shape;
  always_comb begin
    ctl_nxt.edge_v     = has_vertex & ~at_start_r;
    ctl_nxt.close_v    = shape_done;
    ctl_nxt.last_scene = last_in_scene;
  end

  // shape-open flag
  always_comb begin
    at_start_nxt = at_start_r;
    if (acc) begin
      if (has_vertex) at_start_nxt = 1'b0;
      if (shape_done || last_in_scene) at_start_nxt = 1'b1;
    end
  end

  // stage occupancy
  assign s1_v_nxt = acc | (s1_v_r & ~s1_go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
      s1_v_r     <= 1'b0;
    end else begin
      at_start_r <= at_start_nxt;
      s1_v_r     <= s1_v_nxt;
    end
  end

  // vertex history and edge operands
  always_ff @(posedge clk) begin
    if (acc) begin
      ctl_r  <= ctl_nxt;
      tx_r   <= tx;
      ty_r   <= ty;
      e_xi_r <= vx;
      e_yi_r <= vy;
      e_xj_r <= prev_x_r;
      e_yj_r <= prev_y_r;
      c_xi_r <= fx_use;
      c_yi_r <= fy_use;
      if (has_vertex) begin
        first_x_r <= fx_use;
        first_y_r <= fy_use;
        prev_x_r  <= vx;
        prev_y_r  <= vy;
      end
    end
  end

  assign s1_v   = s1_v_r;
  assign s1_ctl = ctl_r;

endmodule
`default_nettype wire

// File: hdl/pht_edge.sv
// one edge crossing unit: differences and cross products, registered
`default_nettype none
module pht_edge import pht_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [CW-1:0] xi,
  input  wire logic signed [CW-1:0] yi,
  input  wire logic signed [CW-1:0] xj,
  input  wire logic signed [CW-1:0] yj,
  input  wire logic signed [CW-1:0] tx,
  input  wire logic signed [CW-1:0] ty,
  output logic                      straddle_r,
  output logic                      dy_pos_r,
  output logic signed [2*CW+1:0]    lhs_r,
  output logic signed [2*CW+1:0]    rhs_r
);

  logic signed [CW:0]     dy, dtx, dxj, dty;
  logic signed [2*CW+1:0] lhs_nxt, rhs_nxt;

  // differences, one bit wider than the coordinates
  assign dy  = (CW+1)'(yj) - (CW+1)'(yi);
  assign dtx = (CW+1)'(tx) - (CW+1)'(xi);
  assign dxj = (CW+1)'(xj) - (CW+1)'(xi);
  assign dty = (CW+1)'(ty) - (CW+1)'(yi);

  // cross-multiplied form of the crossing abscissa compare
  assign lhs_nxt = dtx * dy;
  assign rhs_nxt = dxj * dty;

  always_ff @(posedge clk) begin
    if (en) begin
      straddle_r <= (yi > ty) != (yj > ty);
      dy_pos_r   <= dy > 0;
      lhs_r      <= lhs_nxt;
      rhs_r      <= rhs_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/pht_accum.sv
// parity, shape bookkeeping and result register
`default_nettype none
module pht_accum import pht_pkg::*; #(
  parameter int CW          = COORD_WIDTH_DEF,
  parameter int SHAPE_LIMIT = SHAPE_LIMIT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   s1_go,
  input  wire pht_ctl_t               s1_ctl,
  input  wire logic                   e_straddle,
  input  wire logic                   e_dy_pos,
  input  wire logic signed [2*CW+1:0] e_lhs,
  input  wire logic signed [2*CW+1:0] e_rhs,
  input  wire logic                   c_straddle,
  input  wire logic                   c_dy_pos,
  input  wire logic signed [2*CW+1:0] c_lhs,
  input  wire logic signed [2*CW+1:0] c_rhs,
  output logic                        s2_free,
  pht_out_if.source                   out_chan
);

  localparam int CNT_W = $clog2(SHAPE_LIMIT + 1);

  logic                   s2_v_r, s2_v_nxt, s2_go;
  pht_ctl_t               ctl_r;
  logic                   cross_e, cross_c, par;
  logic                   parity_r, parity_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W+IDX_W-1:0] cnt_ext;
  logic [HIT_W-1:0]       hits_r, hits_nxt, hits_upd;
  logic [IDX_W-1:0]       top_r, top_nxt, top_upd;
  logic                   ovf_r, ovf_nxt, ovf_upd;
  logic                   out_v_r, out_v_nxt;
  logic                   found_r;
  logic [IDX_W-1:0]       idx_r;
  logic [HIT_W-1:0]       cnt_out_r;
  logic                   ovfo_r;

  // strict crossing test, sense set by edge direction
  assign cross_e = e_straddle & (e_dy_pos ? (e_lhs < e_rhs) : (e_lhs > e_rhs));
  assign cross_c = c_straddle & (c_dy_pos ? (c_lhs < c_rhs) : (c_lhs > c_rhs));
  assign par = parity_r ^ (ctl_r.edge_v & cross_e) ^ (ctl_r.close_v & cross_c);

  // a result beat waits for room in the output register
  assign s2_go    = s2_v_r & (~ctl_r.last_scene | ~out_v_r | out_chan.ready);
  assign s2_free  = ~s2_v_r | s2_go;
  assign s2_v_nxt = s1_go | (s2_v_r & ~s2_go);

  assign cnt_ext = {{IDX_W{1'b0}}, cnt_r};

  // shape close: count, record topmost hit or flag overflow; scene end clears the scene state
  always_comb begin
    parity_nxt = par;
    cnt_nxt    = cnt_r;
    hits_upd   = hits_r;
    top_upd    = top_r;
    ovf_upd    = ovf_r;
    if (ctl_r.close_v) begin
      parity_nxt = 1'b0;
      if (cnt_r < CNT_W'(SHAPE_LIMIT)) begin
        if (par) begin
          if (hits_r != HIT_SAT) hits_upd = hits_r + 1'b1;
          top_upd = cnt_ext[IDX_W-1:0];
        end
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        ovf_upd = 1'b1;
      end
    end
    hits_nxt = hits_upd;
    top_nxt  = top_upd;
    ovf_nxt  = ovf_upd;
    if (ctl_r.last_scene) begin
      parity_nxt = 1'b0;
      cnt_nxt    = '0;
      hits_nxt   = '0;
      top_nxt    = '0;
      ovf_nxt    = 1'b0;
    end
  end

  assign out_v_nxt = (s2_go & ctl_r.last_scene) | (out_v_r & ~out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      parity_r <= 1'b0;
      cnt_r    <= '0;
      hits_r   <= '0;
      top_r    <= '0;
      ovf_r    <= 1'b0;
    end else begin
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
      if (s2_go) begin
        parity_r <= parity_nxt;
        cnt_r    <= cnt_nxt;
        hits_r   <= hits_nxt;
        top_r    <= top_nxt;
        ovf_r    <= ovf_nxt;
      end
    end
  end

  // stage control and result payload
  always_ff @(posedge clk) begin
    if (s1_go) ctl_r <= s1_ctl;
    if (s2_go && ctl_r.last_scene) begin
      found_r   <= hits_upd != '0;
      idx_r     <= top_upd;
      cnt_out_r <= hits_upd;
      ovfo_r    <= ovf_upd;
    end
  end

  assign out_chan.valid           = out_v_r;
  assign out_chan.found           = found_r;
  assign out_chan.top_shape_index = idx_r;
  assign out_chan.hit_count       = cnt_out_r;
  assign out_chan.shape_overflow  = ovfo_r;

endmodule
`default_nettype wire

// File: hdl/polygon_hit_test_topmost.sv
// Point-in-polygon hit test over a streamed scene, topmost hit reported.
// The scene's last beat passes the operand register (at the accept edge), the cross-product
// register and the result register before the result beat is valid.
// Throughput: one vertex beat per cycle; four 17x17 multipliers sit in their own stage;
// a result held by out_chan.ready stalls the input once the pipeline is full.
// Reset: synchronous active-low rst_n clears all pipeline valids and scene counters.
`default_nettype none
module polygon_hit_test_topmost import pht_pkg::*; #(
  parameter int SHAPE_LIMIT = SHAPE_LIMIT_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pht_in_if.sink    in_chan,
  pht_out_if.source out_chan
);

  localparam int CW = COORD_WIDTH;

  logic                   acc, s1_v, s1_go, s2_free;
  pht_ctl_t               s1_ctl;
  logic signed [CW-1:0]   tx, ty, e_xi, e_yi, e_xj, e_yj, c_xi, c_yi;
  logic                   e_straddle, e_dy_pos, c_straddle, c_dy_pos;
  logic signed [2*CW+1:0] e_lhs, e_rhs, c_lhs, c_rhs;

  // handshake chain
  assign in_chan.ready = ~s1_v | s1_go;
  assign acc           = in_chan.valid & in_chan.ready;
  assign s1_go         = s1_v & s2_free;

  pht_front #(.CW(CW)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .s1_go         (s1_go),
    .point_x       (in_chan.point_x),
    .point_y       (in_chan.point_y),
    .vertex_x      (in_chan.vertex_x),
    .vertex_y      (in_chan.vertex_y),
    .has_vertex    (in_chan.has_vertex),
    .last_in_shape (in_chan.last_in_shape),
    .last_in_scene (in_chan.last_in_scene),
    .s1_v          (s1_v),
    .s1_ctl        (s1_ctl),
    .tx_r          (tx),
    .ty_r          (ty),
    .e_xi_r        (e_xi),
    .e_yi_r        (e_yi),
    .e_xj_r        (e_xj),
    .e_yj_r        (e_yj),
    .c_xi_r        (c_xi),
    .c_yi_r        (c_yi)
  );

  // edge from the current vertex back to the previous one
  pht_edge #(.CW(CW)) u_edge (
    .clk        (clk),
    .en         (s1_go),
    .xi         (e_xi),
    .yi         (e_yi),
    .xj         (e_xj),
    .yj         (e_yj),
    .tx         (tx),
    .ty         (ty),
    .straddle_r (e_straddle),
    .dy_pos_r   (e_dy_pos),
    .lhs_r      (e_lhs),
    .rhs_r      (e_rhs)
  );

  // closing edge from the first vertex to the current one
  pht_edge #(.CW(CW)) u_close (
    .clk        (clk),
    .en         (s1_go),
    .xi         (c_xi),
    .yi         (c_yi),
    .xj         (e_xi),
    .yj         (e_yi),
    .tx         (tx),
    .ty         (ty),
    .straddle_r (c_straddle),
    .dy_pos_r   (c_dy_pos),
    .lhs_r      (c_lhs),
    .rhs_r      (c_rhs)
  );

  pht_accum #(.CW(CW), .SHAPE_LIMIT(SHAPE_LIMIT)) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_go      (s1_go),
    .s1_ctl     (s1_ctl),
    .e_straddle (e_straddle),
    .e_dy_pos   (e_dy_pos),
    .e_lhs      (e_lhs),
    .e_rhs      (e_rhs),
    .c_straddle (c_straddle),
    .c_dy_pos   (c_dy_pos),
    .c_lhs      (c_lhs),
    .c_rhs      (c_rhs),
    .s2_free    (s2_free),
    .out_chan   (out_chan)
  );

endmodule
`default_nettype wire
